// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants of the websocket frame deframer.
package wsd_pkg;

  localparam int unsigned LEN_W = 17;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'd65536;

  // Opcodes of the frame header.
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Header byte fields and the two extended-length codes.
  localparam logic [7:0] FIN_MASK      = 8'h80;
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Register indexes.
  localparam logic REG_MAX_FRAME_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_PAY  = 3'd3,
    PH_HALT = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_TEXT  = 3'd0,
    K_EMPTY = 3'd1,
    K_PONG  = 3'd2,
    K_CLOSE = 3'd3,
    K_NOFIN = 3'd4,
    K_LONG  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ===== hw/rtl/wsd_regs.sv =====
// APB configuration register of the deframer.
module wsd_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [wsd_pkg::LEN_W-1:0] max_frame_length
);
  import wsd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (wr_en && (paddr[2] == REG_MAX_FRAME_LENGTH)) begin
      max_frame_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_FRAME_LENGTH) begin
      prdata = {{(32-LEN_W){1'b0}}, max_frame_length};
    end
  end

endmodule

// ===== hw/rtl/wsd_parser.sv =====
// Frame header state machine and payload counter; one byte per request.
module wsd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                rx_byte,
  input  logic [wsd_pkg::LEN_W-1:0] max_frame_length,
  output logic                      res_valid,
  output wsd_pkg::result_t          res
);
  import wsd_pkg::*;

  phase_t           phase, phase_next;
  logic [3:0]       frame_opcode, frame_opcode_next;
  logic [3:0]       ext_bytes_left, ext_bytes_left_next;
  // The extended length is kept as its low bits plus a flag for any set bit above them.
  logic [LEN_W-1:0] len_low, len_low_next;
  logic             len_big, len_big_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;

  logic             hd;
  logic [LEN_W-1:0] hd_low;
  logic             hd_big;
  logic [LEN_W-1:0] rem_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      frame_opcode    <= 4'd0;
      ext_bytes_left  <= 4'd0;
      len_low         <= '0;
      len_big         <= 1'b0;
      bytes_remaining <= '0;
    end else begin
      phase           <= phase_next;
      frame_opcode    <= frame_opcode_next;
      ext_bytes_left  <= ext_bytes_left_next;
      len_low         <= len_low_next;
      len_big         <= len_big_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  assign rem_dec = bytes_remaining - {{(LEN_W-1){1'b0}}, 1'b1};

  always_comb begin
    phase_next           = phase;
    frame_opcode_next    = frame_opcode;
    ext_bytes_left_next  = ext_bytes_left;
    len_low_next         = len_low;
    len_big_next         = len_big;
    bytes_remaining_next = bytes_remaining;
    hd                   = 1'b0;
    hd_low               = len_low;
    hd_big               = len_big;
    res_valid            = 1'b0;
    res                  = '{kind: K_TEXT, data: 8'd0, last: 1'b0};

    if (accept) begin
      case (phase)
        PH_HDR0: begin
          frame_opcode_next = rx_byte[3:0];
          if ((rx_byte & FIN_MASK) == 8'd0) begin
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res.kind   = K_NOFIN;
          end else begin
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          len_low_next = '0;
          len_big_next = 1'b0;
          if (rx_byte[6:0] == LEN_CODE_EXT16) begin
            ext_bytes_left_next = EXT16_BYTES;
            phase_next          = PH_EXT;
          end else if (rx_byte[6:0] == LEN_CODE_EXT64) begin
            ext_bytes_left_next = EXT64_BYTES;
            phase_next          = PH_EXT;
          end else begin
            hd_low       = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
            hd_big       = 1'b0;
            len_low_next = hd_low;
            hd           = 1'b1;
          end
        end
        PH_EXT: begin
          hd_low              = {len_low[LEN_W-9:0], rx_byte};
          hd_big              = len_big || (len_low[LEN_W-1:LEN_W-8] != 8'd0);
          len_low_next        = hd_low;
          len_big_next        = hd_big;
          ext_bytes_left_next = ext_bytes_left - 4'd1;
          if (ext_bytes_left == 4'd1) begin
            hd = 1'b1;
          end
        end
        PH_PAY: begin
          bytes_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_HDR0;
          end
          if (frame_opcode == OP_TEXT) begin
            res_valid = 1'b1;
            res.kind  = K_TEXT;
            res.data  = rx_byte;
            res.last  = (rem_dec == '0);
          end else if (rem_dec == '0) begin
            if (frame_opcode == OP_PING) begin
              res_valid = 1'b1;
              res.kind  = K_PONG;
            end else if (frame_opcode == OP_CLOSE) begin
              res_valid  = 1'b1;
              res.kind   = K_CLOSE;
              phase_next = PH_HALT;
            end
          end
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase

      // Header complete: the length check comes before any opcode handling.
      if (hd) begin
        if (hd_big || (hd_low > max_frame_length)) begin
          phase_next = PH_HALT;
          res_valid  = 1'b1;
          res.kind   = K_LONG;
        end else begin
          bytes_remaining_next = hd_low;
          if (hd_low != '0) begin
            phase_next = PH_PAY;
          end else begin
            phase_next = PH_HDR0;
            if (frame_opcode == OP_TEXT) begin
              res_valid = 1'b1;
              res.kind  = K_EMPTY;
            end else if (frame_opcode == OP_PING) begin
              res_valid = 1'b1;
              res.kind  = K_PONG;
            end else if (frame_opcode == OP_CLOSE) begin
              res_valid  = 1'b1;
              res.kind   = K_CLOSE;
              phase_next = PH_HALT;
            end
          end
        end
      end
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |=> (phase == PH_HALT))
    else $error("deframer left the halted phase");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |-> !res_valid)
    else $error("result produced while halted");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY) |-> (bytes_remaining != '0))
    else $error("payload phase with zero bytes remaining");

  a_data_only_text: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.kind != K_TEXT)) |-> ((res.data == 8'd0) && !res.last))
    else $error("data or last set on a non-text result");

endmodule

// ===== hw/rtl/wsd_out_fifo.sv =====
// Two-entry result queue that decouples the parser from the output stream.
module wsd_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsd_pkg::result_t push_data,
  output logic             has_room,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t out_data
);
  import wsd_pkg::*;

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> has_room)
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    ((count == 2'd0) || (count == 2'd2)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Websocket frame deframer: one received byte per request, text bytes and events out.
// Each result is written into the result queue as its byte is accepted; the master side reads it from there.
// Throughput: one byte per cycle; s_tready drops only while two results wait untaken.
// Reset (rst, synchronous, active high): header phase, empty result queue,
// max_frame_length back to 65536; a halted block resumes only after reset.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Received bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] data
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast
);
  import wsd_pkg::*;

  logic             [LEN_W-1:0] max_frame_length;
  logic             accept;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign accept = s_tvalid && s_tready;

  wsd_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .max_frame_length (max_frame_length)
  );

  wsd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (s_tdata),
    .max_frame_length (max_frame_length),
    .res_valid        (res_valid),
    .res              (res)
  );

  wsd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = out_res.data;
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule
